FILE: rtl/core/fm_phase_discriminator_defines.svh
// assertion macros for the fm phase discriminator
`ifndef FM_PHASE_DISCRIMINATOR_DEFINES_SVH
`define FM_PHASE_DISCRIMINATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FMPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define FMPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/fmpd_pkg.sv
// shared constants and angle table for the fm phase discriminator
`default_nettype none

package fmpd_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int GAIN_BITS = 16;
  localparam int FREQ_BITS = 32;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd1229;

  // samples are scaled up to this many bits before rotation
  localparam int PRESCALE_TOTAL = 40;
  // datapath width: scaled sample plus cordic gain and sign
  localparam int CORDIC_W = PRESCALE_TOTAL + 2;

  // angle accumulator in units of 2^-32 turn
  localparam int ANGLE_BITS = 32;
  localparam logic [ANGLE_BITS-1:0] QUARTER_POS = 32'h4000_0000;
  localparam logic [ANGLE_BITS-1:0] QUARTER_NEG = 32'hC000_0000;

  // atan(2^-k) in 2^-32 turn units, truncated
  function automatic logic [ANGLE_BITS-1:0] atan_turns(input logic [4:0] idx);
    logic [ANGLE_BITS-1:0] val;
    unique case (idx)
      5'd0:    val = 32'h2000_0000;
      5'd1:    val = 32'h12E4_051D;
      5'd2:    val = 32'h09FB_385B;
      5'd3:    val = 32'h0511_11D4;
      5'd4:    val = 32'h028B_0D43;
      5'd5:    val = 32'h0145_D7E1;
      5'd6:    val = 32'h00A2_F61E;
      5'd7:    val = 32'h0051_7C55;
      5'd8:    val = 32'h0028_BE53;
      5'd9:    val = 32'h0014_5F2E;
      5'd10:   val = 32'h000A_2F98;
      5'd11:   val = 32'h0005_17CC;
      5'd12:   val = 32'h0002_8BE6;
      5'd13:   val = 32'h0001_45F3;
      5'd14:   val = 32'h0000_A2F9;
      5'd15:   val = 32'h0000_517C;
      5'd16:   val = 32'h0000_28BE;
      5'd17:   val = 32'h0000_145F;
      5'd18:   val = 32'h0000_0A2F;
      5'd19:   val = 32'h0000_0517;
      5'd20:   val = 32'h0000_028B;
      5'd21:   val = 32'h0000_0145;
      5'd22:   val = 32'h0000_00A2;
      5'd23:   val = 32'h0000_0051;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fm_phase_discriminator.sv
// fm phase discriminator: cordic atan2 phase, phase step, gain multiply
// path: a sample passes the cordic input, stage and output registers, the mid fifo and the result register
// throughput: one sample per cycle while full is low, set by the fully pipelined cordic stages
// a credit count over the mid fifo raises full only when the result side stalls
// reset: synchronous, clears all valid bits and pointers, previous phase to 0, gain to 1229
`default_nettype none

`include "fm_phase_discriminator_defines.svh"

module fm_phase_discriminator #(
  parameter int SAMPLE_BITS   = fmpd_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS    = fmpd_pkg::PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic signed [SAMPLE_BITS-1:0]    in_phase,
  input  wire logic signed [SAMPLE_BITS-1:0]    quadrature,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic signed [fmpd_pkg::FREQ_BITS-1:0] inst_frequency,
  output logic signed [PHASE_BITS-1:0]          sample_phase,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [fmpd_pkg::GAIN_BITS-1:0]   cfg_data
);

  // room for every sample in the cordic pipe plus slack
  localparam int MID_DEPTH = 2 ** $clog2(CORDIC_STAGES + 4);
  localparam int CNT_W     = $clog2(MID_DEPTH + 1);

  logic [fmpd_pkg::GAIN_BITS-1:0] rate_over_carrier_gain;
  logic [CNT_W-1:0]               inflight;
  logic                           accept;
  logic                           mid_push, mid_pop, mid_empty;
  logic [PHASE_BITS-1:0]          front_phase, mid_phase;

  assign cfg_ready = 1'b1;
  assign full      = (inflight == CNT_W'(MID_DEPTH));
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_over_carrier_gain <= fmpd_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      rate_over_carrier_gain <= cfg_data;
    end
  end

  // samples accepted and not yet taken from the mid fifo
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      unique case ({accept, mid_pop})
        2'b10:   inflight <= inflight + CNT_W'(1);
        2'b01:   inflight <= inflight - CNT_W'(1);
        default: inflight <= inflight;
      endcase
    end
  end

  fmpd_cordic #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .PHASE_BITS    (PHASE_BITS),
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .in_phase   (in_phase),
    .quadrature (quadrature),
    .out_valid  (mid_push),
    .out_phase  (front_phase)
  );

  fmpd_queue #(
    .WIDTH (PHASE_BITS),
    .DEPTH (MID_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (front_phase),
    .rd_en   (mid_pop),
    .rd_data (mid_phase),
    .empty   (mid_empty)
  );

  fmpd_back #(
    .PHASE_BITS (PHASE_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .avail          (!mid_empty),
    .phase          (mid_phase),
    .gain           (rate_over_carrier_gain),
    .pop            (pop),
    .take           (mid_pop),
    .empty          (empty),
    .inst_frequency (inst_frequency),
    .sample_phase   (sample_phase)
  );

  `FMPD_ASSERT_NOW(a_credit_bound, 1'b1, inflight <= CNT_W'(MID_DEPTH), "credit count above fifo depth")
  `FMPD_ASSERT_NOW(a_push_has_credit, mid_push, inflight != '0, "front beat without credit")
  `FMPD_ASSERT_NOW(a_pop_has_credit, mid_pop, inflight != '0, "mid fifo read without credit")
  `FMPD_ASSERT_NEXT(a_take_loads_result, mid_pop, !empty, "result register not loaded")

endmodule

`default_nettype wire

FILE: rtl/core/fmpd_cordic.sv
// front end: pipelined cordic vectoring atan2, one sample per cycle
`default_nettype none

module fmpd_cordic #(
  parameter int SAMPLE_BITS   = fmpd_pkg::SAMPLE_BITS_DEF,
  parameter int PHASE_BITS    = fmpd_pkg::PHASE_BITS_DEF,
  parameter int CORDIC_STAGES = fmpd_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic signed [SAMPLE_BITS-1:0] in_phase,
  input  wire logic signed [SAMPLE_BITS-1:0] quadrature,
  output logic                               out_valid,
  output logic [PHASE_BITS-1:0]              out_phase
);

  localparam int CW  = fmpd_pkg::CORDIC_W;
  localparam int AB  = fmpd_pkg::ANGLE_BITS;
  localparam int PRE = fmpd_pkg::PRESCALE_TOTAL - SAMPLE_BITS;
  localparam logic [AB-1:0] ROUND = AB'(1) << (AB - 1 - PHASE_BITS);

  logic signed [CW-1:0] ii_s, qq_s;
  logic signed [CW-1:0] x_pre, y_pre;
  logic [AB-1:0]        z_pre;

  logic signed [CW-1:0] xs     [CORDIC_STAGES+1];
  logic signed [CW-1:0] ys     [CORDIC_STAGES+1];
  logic [AB-1:0]        zs     [CORDIC_STAGES+1];
  logic                 zero_s [CORDIC_STAGES+1];
  logic                 vld    [CORDIC_STAGES+1];

  logic [AB-1:0] z_round;

  assign ii_s = CW'(in_phase) <<< PRE;
  assign qq_s = CW'(quadrature) <<< PRE;

  // left half plane is turned by a quarter turn first
  always_comb begin
    x_pre = ii_s;
    y_pre = qq_s;
    z_pre = '0;
    if (ii_s[CW-1]) begin
      if (!qq_s[CW-1]) begin
        x_pre = qq_s;
        y_pre = -ii_s;
        z_pre = fmpd_pkg::QUARTER_POS;
      end else begin
        x_pre = -qq_s;
        y_pre = ii_s;
        z_pre = fmpd_pkg::QUARTER_NEG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]     <= x_pre;
    ys[0]     <= y_pre;
    zs[0]     <= z_pre;
    zero_s[0] <= (in_phase == '0) && (quadrature == '0);
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      zero_s[k+1] <= zero_s[k];
      if (!ys[k][CW-1]) begin
        xs[k+1] <= xs[k] + (ys[k] >>> k);
        ys[k+1] <= ys[k] - (xs[k] >>> k);
        zs[k+1] <= zs[k] + fmpd_pkg::atan_turns(5'(k));
      end else begin
        xs[k+1] <= xs[k] - (ys[k] >>> k);
        ys[k+1] <= ys[k] + (xs[k] >>> k);
        zs[k+1] <= zs[k] - fmpd_pkg::atan_turns(5'(k));
      end
    end
  end

  assign z_round = zs[CORDIC_STAGES] + ROUND;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[CORDIC_STAGES];
    end
  end

  // zero vector has no angle, report zero
  always_ff @(posedge clk) begin
    if (zero_s[CORDIC_STAGES]) begin
      out_phase <= '0;
    end else begin
      out_phase <= z_round[AB-1 -: PHASE_BITS];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fmpd_queue.sv
// small fifo between the cordic front end and the frequency back end
`default_nettype none

module fmpd_queue #(
  parameter int WIDTH = fmpd_pkg::PHASE_BITS_DEF,
  parameter int DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;
  logic             head_valid;
  logic             mem_empty, head_load, mem_wr, mem_rd;

  // head register holds the oldest beat, the memory holds the rest
  assign mem_empty = (count == '0);
  assign head_load = !head_valid || rd_en;
  assign mem_rd    = head_load && !mem_empty;
  assign mem_wr    = wr_en && !(head_load && mem_empty);
  assign empty     = !head_valid;

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // a beat into an empty queue goes straight to the head register
  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= mem[rd_ptr];
    end else if (head_load && wr_en) begin
      rd_data <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
      head_valid <= 1'b0;
    end else begin
      if (mem_wr) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (mem_rd) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (head_load) begin
        head_valid <= mem_rd || wr_en;
      end
      unique case ({mem_wr, mem_rd})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fmpd_back.sv
// back end: phase step against previous sample, gain multiply, result register
`default_nettype none

module fmpd_back #(
  parameter int PHASE_BITS = fmpd_pkg::PHASE_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            avail,
  input  wire logic [PHASE_BITS-1:0]           phase,
  input  wire logic [fmpd_pkg::GAIN_BITS-1:0]  gain,
  input  wire logic                            pop,
  output logic                                 take,
  output logic                                 empty,
  output logic signed [fmpd_pkg::FREQ_BITS-1:0] inst_frequency,
  output logic signed [PHASE_BITS-1:0]         sample_phase
);

  localparam int PW = PHASE_BITS + fmpd_pkg::GAIN_BITS + 1;

  logic                         out_valid;
  logic [PHASE_BITS-1:0]        previous_phase;
  logic signed [PHASE_BITS-1:0] step;
  logic signed [PW-1:0]         prod;

  // two's complement wrap of the difference is the half-turn unwrap
  assign step = $signed(phase - previous_phase);
  assign prod = PW'(step) * PW'($signed({1'b0, gain}));

  assign empty = !out_valid;
  assign take  = avail && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_phase <= '0;
    end else begin
      if (take) begin
        out_valid      <= 1'b1;
        previous_phase <= phase;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      inst_frequency <= fmpd_pkg::FREQ_BITS'(prod);
      sample_phase   <= $signed(phase);
    end
  end

endmodule

`default_nettype wire
